/* rtl/core/dss_pkg.sv */
// Shared types and constants of the dependency step scoreboard.
package dss_pkg;

	localparam int MaskW  = 32;
	localparam int KindW  = 3;
	localparam int IdxW   = 5;
	localparam int StepsW = 6;
	localparam int CountW = 7;

	localparam logic [StepsW-1:0] StepsReset = 6'd32;

	typedef enum logic [KindW-1:0] {
		KIND_LOAD_DEPS    = 3'd0,
		KIND_REQUEST      = 3'd1,
		KIND_RESET_STEPS  = 3'd2,
		KIND_RESET_ALL    = 3'd3,
		KIND_POLL         = 3'd4,
		KIND_RESET_FAILED = 3'd5
	} dss_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_SUM1,
		ST_SUM2,
		ST_FINISH
	} dss_state_t;

	// Per-step view of the scoreboard that one lane needs.
	typedef struct packed {
		logic       acc;
		logic       in_use;
		logic       runnable;
		logic       requested;
		logic [2:0] diff;
	} dss_lane_in_t;

	// What one lane reports to the merging stage.
	typedef struct packed {
		logic [MaskW-1:0] contrib;
		logic             ready;
		logic [1:0]       chg;
	} dss_lane_res_t;

endpackage

/* rtl/core/dss_if.sv */
// Channel interfaces of the scoreboard: item input, result output and configuration.
interface dss_in_if;
	logic                        valid;
	logic                        ready;
	logic [dss_pkg::KindW-1:0]   kind;
	logic [dss_pkg::IdxW-1:0]    step_index;
	logic [dss_pkg::MaskW-1:0]   step_bits;
	logic                        include_running;
	logic [dss_pkg::MaskW-1:0]   dispatch_ok_mask;
	logic [dss_pkg::MaskW-1:0]   dispatch_fail_mask;
	logic [dss_pkg::MaskW-1:0]   poll_done_mask;
	logic [dss_pkg::MaskW-1:0]   poll_fail_mask;

	modport source (
		output valid, kind, step_index, step_bits, include_running,
		output dispatch_ok_mask, dispatch_fail_mask, poll_done_mask, poll_fail_mask,
		input  ready
	);
	modport sink (
		input  valid, kind, step_index, step_bits, include_running,
		input  dispatch_ok_mask, dispatch_fail_mask, poll_done_mask, poll_fail_mask,
		output ready
	);
endinterface

interface dss_out_if;
	logic                        valid;
	logic                        ready;
	logic [dss_pkg::MaskW-1:0]   requested_now;
	logic [dss_pkg::MaskW-1:0]   runnable_now;
	logic [dss_pkg::MaskW-1:0]   running_now;
	logic [dss_pkg::MaskW-1:0]   complete_now;
	logic [dss_pkg::MaskW-1:0]   passed_now;
	logic [dss_pkg::MaskW-1:0]   failed_view;
	logic [dss_pkg::CountW-1:0]  transitions;

	modport source (
		output valid, requested_now, runnable_now, running_now, complete_now,
		output passed_now, failed_view, transitions,
		input  ready
	);
	modport sink (
		input  valid, requested_now, runnable_now, running_now, complete_now,
		input  passed_now, failed_view, transitions,
		output ready
	);
endinterface

interface dss_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dss_pkg::StepsW-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/core/dss_lane.sv */
// One step lane: holds the step's dependency row and evaluates it against the masks.
module dss_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [dss_pkg::MaskW-1:0]    wr_data,
	input  logic [dss_pkg::MaskW-1:0]    valid_m,
	input  logic [dss_pkg::MaskW-1:0]    passed,
	input  dss_pkg::dss_lane_in_t        lin,
	output dss_pkg::dss_lane_res_t       lres
);

	logic [dss_pkg::MaskW-1:0] dep_q;
	logic [dss_pkg::MaskW-1:0] dep_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q <= '0;
		end else if (wr_en) begin
			dep_q <= wr_data;
		end
	end

	assign dep_m = dep_q & valid_m;

	always_comb begin
		lres.contrib = lin.acc ? dep_m : '0;
		// A requested step in use becomes runnable once every dependency in use has passed.
		lres.ready   = lin.in_use & ~lin.runnable & lin.requested & ((passed & dep_m) == dep_m);
		lres.chg     = 2'(lin.diff[0]) + 2'(lin.diff[1]) + 2'(lin.diff[2]);
	end

endmodule

/* rtl/core/dss_merge.sv */
// Merging stage: ORs the lanes' closure terms and sums their change counts in two stages.
module dss_merge #(
	parameter int NumLanes = 32
) (
	input  logic                          clk,
	input  dss_pkg::dss_lane_res_t        lane_res [NumLanes],
	output logic [dss_pkg::MaskW-1:0]     closure_or,
	output logic [dss_pkg::CountW-1:0]    total_s2
);

	localparam int Groups = (NumLanes + 7) / 8;

	logic [1:0] chg_pad [Groups*8];
	logic [4:0] part_s1 [Groups];

	always_comb begin
		closure_or = '0;
		for (int i = 0; i < NumLanes; i++) begin
			closure_or = closure_or | lane_res[i].contrib;
		end
	end

	for (genvar k = 0; k < Groups * 8; k++) begin : g_pad
		if (k < NumLanes) begin : g_lane
			assign chg_pad[k] = lane_res[k].chg;
		end else begin : g_zero
			assign chg_pad[k] = '0;
		end
	end

	for (genvar g = 0; g < Groups; g++) begin : g_part
		always_ff @(posedge clk) begin
			logic [4:0] s;
			s = '0;
			for (int j = 0; j < 8; j++) begin
				s = s + 5'(chg_pad[g*8+j]);
			end
			part_s1[g] <= s;
		end
	end

	always_ff @(posedge clk) begin
		logic [dss_pkg::CountW-1:0] t;
		t = '0;
		for (int g = 0; g < Groups; g++) begin
			t = t + dss_pkg::CountW'(part_s1[g]);
		end
		total_s2 <= t;
	end

endmodule

/* rtl/core/dependency_step_scoreboard.sv */
// Flow: an item is taken in IDLE and its result is registered at the output from FINISH, once the
// output register is free; a request first runs closure passes in CLOSE until a pass adds no step,
// and a poll tick first passes SUM1 and SUM2 (the two registered stages of the change-count tree).
// Throughput: one item at a time; the next item is taken as soon as the result is registered,
// even while it waits at the output. Reset clears the status masks and dependency rows at once and
// sets the step count to 32; no clearing pass is needed.
module dependency_step_scoreboard #(
	parameter int MAX_STEPS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dss_cfg_if.sink     cfg,
	dss_in_if.sink      item,
	dss_out_if.source   result
);

	localparam int MaskW = dss_pkg::MaskW;
	localparam logic [MaskW-1:0] LaneMask = {MaskW{1'b1}} >> (MaskW - MAX_STEPS);

	dss_pkg::dss_state_t state_q, state_d;

	logic [dss_pkg::StepsW-1:0] steps_q;
	logic [MaskW-1:0] valid_m;

	logic [MaskW-1:0] req_q, rnb_q, run_q, cmp_q, pas_q, acc_q;
	logic [MaskW-1:0] req_d, rnb_d, run_d, cmp_d, pas_d, acc_d;
	logic [MaskW-1:0] xr_q, xc_q, xd_q, xr_d, xc_d, xd_d;
	logic inc_q, inc_d, is_poll_q, is_poll_d;

	logic in_acc, out_load, out_valid_q;
	logic [MaskW-1:0] fresh, closure_or, clos_next;
	logic [dss_pkg::CountW-1:0] total_s2;

	// Poll tick terms.
	logic [MaskW-1:0] pre_disp, sel1, fd, od, r1, c1, p1, sel2, pf, pd, r2, c2, p2, n1, post_disp;
	logic [MaskW-1:0] scope_rf;

	dss_pkg::dss_lane_res_t lane_res [MAX_STEPS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= dss_pkg::StepsReset;
		end else if (cfg.valid) begin
			steps_q <= cfg.data;
		end
	end

	always_comb begin
		if (steps_q >= dss_pkg::StepsW'(MAX_STEPS)) begin
			valid_m = LaneMask;
		end else begin
			valid_m = ~({MaskW{1'b1}} << steps_q);
		end
	end

	assign item.ready = (state_q == dss_pkg::ST_IDLE);
	assign in_acc     = item.valid & item.ready;

	for (genvar i = 0; i < MaskW; i++) begin : g_lane
		if (i < MAX_STEPS) begin : g_used
			dss_pkg::dss_lane_in_t lin;
			logic wr_en;

			assign lin.acc       = acc_q[i];
			assign lin.in_use    = valid_m[i];
			assign lin.runnable  = rnb_q[i];
			assign lin.requested = req_q[i];
			assign lin.diff      = {xr_q[i], xc_q[i], xd_q[i]};
			assign wr_en = in_acc && (item.kind == dss_pkg::KIND_LOAD_DEPS)
				&& (item.step_index == dss_pkg::IdxW'(i));

			dss_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr_en   (wr_en),
				.wr_data (item.step_bits),
				.valid_m (valid_m),
				.passed  (pas_q),
				.lin     (lin),
				.lres    (lane_res[i])
			);

			assign fresh[i] = lane_res[i].ready;
		end else begin : g_absent
			assign fresh[i] = 1'b0;
		end
	end

	dss_merge #(.NumLanes(MAX_STEPS)) u_merge (
		.clk        (clk),
		.lane_res   (lane_res),
		.closure_or (closure_or),
		.total_s2   (total_s2)
	);

	assign clos_next = acc_q | closure_or;

	always_comb begin
		n1       = rnb_q | fresh;
		pre_disp = rnb_q & ~cmp_q & ~run_q;
		sel1     = pre_disp & valid_m;
		fd       = sel1 & item.dispatch_fail_mask;
		od       = sel1 & item.dispatch_ok_mask & ~item.dispatch_fail_mask;
		r1       = (run_q & ~fd) | od;
		c1       = (cmp_q & ~od) | fd;
		p1       = pas_q & ~(fd | od);
		sel2     = r1 & valid_m;
		pf       = sel2 & item.poll_fail_mask;
		pd       = sel2 & item.poll_done_mask & ~item.poll_fail_mask;
		r2       = r1 & ~(pf | pd);
		c2       = c1 | pf | pd;
		p2       = (p1 & ~pf) | pd;
		post_disp = n1 & ~c2 & ~r2;
		scope_rf = (item.include_running ? rnb_q : cmp_q) & ~pas_q;
	end

	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		rnb_d     = rnb_q;
		run_d     = run_q;
		cmp_d     = cmp_q;
		pas_d     = pas_q;
		acc_d     = acc_q;
		xr_d      = xr_q;
		xc_d      = xc_q;
		xd_d      = xd_q;
		inc_d     = inc_q;
		is_poll_d = is_poll_q;
		out_load  = 1'b0;
		case (state_q)
			dss_pkg::ST_IDLE: begin
				if (in_acc) begin
					inc_d     = item.include_running;
					is_poll_d = (item.kind == dss_pkg::KIND_POLL);
					state_d   = dss_pkg::ST_FINISH;
					case (item.kind)
						dss_pkg::KIND_REQUEST: begin
							acc_d   = item.step_bits & valid_m;
							state_d = dss_pkg::ST_CLOSE;
						end
						dss_pkg::KIND_RESET_STEPS: begin
							req_d = req_q & ~item.step_bits;
							rnb_d = rnb_q & ~item.step_bits;
							run_d = run_q & ~item.step_bits;
							cmp_d = cmp_q & ~item.step_bits;
							pas_d = pas_q & ~item.step_bits;
						end
						dss_pkg::KIND_RESET_ALL: begin
							req_d = '0;
							rnb_d = '0;
							run_d = '0;
							cmp_d = '0;
							pas_d = '0;
						end
						dss_pkg::KIND_POLL: begin
							rnb_d   = n1;
							run_d   = r2;
							cmp_d   = c2;
							pas_d   = p2;
							xr_d    = run_q ^ r2;
							xc_d    = cmp_q ^ c2;
							xd_d    = pre_disp ^ post_disp;
							state_d = dss_pkg::ST_SUM1;
						end
						dss_pkg::KIND_RESET_FAILED: begin
							run_d = run_q & ~scope_rf;
							cmp_d = cmp_q & ~scope_rf;
						end
						default: begin
						end
					endcase
				end
			end
			dss_pkg::ST_CLOSE: begin
				// The closure is done when a pass adds no new step.
				if (clos_next == acc_q) begin
					req_d   = req_q | acc_q;
					state_d = dss_pkg::ST_FINISH;
				end else begin
					acc_d = clos_next;
				end
			end
			dss_pkg::ST_SUM1: state_d = dss_pkg::ST_SUM2;
			dss_pkg::ST_SUM2: state_d = dss_pkg::ST_FINISH;
			dss_pkg::ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = dss_pkg::ST_IDLE;
				end
			end
			default: state_d = dss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dss_pkg::ST_IDLE;
			req_q       <= '0;
			rnb_q       <= '0;
			run_q       <= '0;
			cmp_q       <= '0;
			pas_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			req_q   <= req_d;
			rnb_q   <= rnb_d;
			run_q   <= run_d;
			cmp_q   <= cmp_d;
			pas_q   <= pas_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q     <= acc_d;
		xr_q      <= xr_d;
		xc_q      <= xc_d;
		xd_q      <= xd_d;
		inc_q     <= inc_d;
		is_poll_q <= is_poll_d;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.requested_now <= req_q;
			result.runnable_now  <= rnb_q;
			result.running_now   <= run_q;
			result.complete_now  <= cmp_q;
			result.passed_now    <= pas_q;
			result.failed_view   <= (inc_q ? rnb_q : cmp_q) & ~pas_q;
			result.transitions   <= is_poll_q ? total_s2 : '0;
		end
	end

	assign result.valid = out_valid_q;

endmodule

/* rtl/core/dss_checker.sv */
// Port-level checker for the scoreboard's result beats, bound to the top level.
module dss_port_checks (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [dss_pkg::MaskW-1:0]     requested_now,
	input logic [dss_pkg::MaskW-1:0]     runnable_now,
	input logic [dss_pkg::MaskW-1:0]     running_now,
	input logic [dss_pkg::MaskW-1:0]     complete_now,
	input logic [dss_pkg::MaskW-1:0]     passed_now,
	input logic [dss_pkg::CountW-1:0]    transitions
);

	// A step only passes by completing, and leaving complete also drops the pass.
	a_passed_in_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((passed_now & ~complete_now) == '0))
		else $error("passed step that is not complete");

	a_run_cmp_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((running_now & complete_now) == '0))
		else $error("step both running and complete");

	a_runnable_requested: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((runnable_now & ~requested_now) == '0))
		else $error("runnable step that is not requested");

	a_trans_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (transitions <= dss_pkg::CountW'(96)))
		else $error("transition count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(passed_now)
			&& $stable(transitions))
		else $error("result beat changed while stalled");

endmodule

bind dependency_step_scoreboard dss_port_checks u_dss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.requested_now (result.requested_now),
	.runnable_now  (result.runnable_now),
	.running_now   (result.running_now),
	.complete_now  (result.complete_now),
	.passed_now    (result.passed_now),
	.transitions   (result.transitions)
);

/* verif/dss_checker.sv */
// Checker for the dependency step scoreboard: predicts every result beat and compares it.
`timescale 1ns / 100ps
module dss_checker (
	input  logic        clk,
	input  logic        arst_n,
	dss_cfg_if          cfg,
	dss_in_if           item,
	dss_out_if          result,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned checked
);

	typedef struct packed {
		logic [dss_pkg::MaskW-1:0]  requested;
		logic [dss_pkg::MaskW-1:0]  runnable;
		logic [dss_pkg::MaskW-1:0]  running;
		logic [dss_pkg::MaskW-1:0]  complete;
		logic [dss_pkg::MaskW-1:0]  passed;
		logic [dss_pkg::MaskW-1:0]  failed;
		logic [dss_pkg::CountW-1:0] transitions;
	} mask_view_t;

	logic [dss_pkg::MaskW-1:0]  dep_rows [0:31];
	logic [dss_pkg::MaskW-1:0]  req_m;
	logic [dss_pkg::MaskW-1:0]  runnable_m;
	logic [dss_pkg::MaskW-1:0]  running_m;
	logic [dss_pkg::MaskW-1:0]  complete_m;
	logic [dss_pkg::MaskW-1:0]  passed_m;
	logic [dss_pkg::StepsW-1:0] step_count;
	mask_view_t                 expected_views [$];

	function automatic logic [dss_pkg::MaskW-1:0] in_use_bits();
		if (step_count >= 6'd32)
			return '1;
		return (32'd1 << step_count) - 32'd1;
	endfunction

	// Grows the requested set by dependency rows until nothing new appears.
	function automatic logic [dss_pkg::MaskW-1:0] dependency_closure(
			input logic [dss_pkg::MaskW-1:0] seed,
			input logic [dss_pkg::MaskW-1:0] in_use);
		logic [dss_pkg::MaskW-1:0] acc;
		logic [dss_pkg::MaskW-1:0] grown;
		int                        round;
		int                        s;
		acc = seed & in_use;
		for (round = 0; round < 33; round++) begin
			grown = acc;
			for (s = 0; s < 32; s++)
				if (acc[s])
					grown |= dep_rows[s] & in_use;
			if (grown == acc)
				break;
			acc = grown;
		end
		return acc;
	endfunction

	task automatic apply_item(input logic [dss_pkg::KindW-1:0] kind,
			input logic [dss_pkg::IdxW-1:0] row,
			input logic [dss_pkg::MaskW-1:0] mask, input logic scope_runnable,
			input logic [dss_pkg::MaskW-1:0] d_ok, input logic [dss_pkg::MaskW-1:0] d_fail,
			input logic [dss_pkg::MaskW-1:0] p_done, input logic [dss_pkg::MaskW-1:0] p_fail);
		logic [dss_pkg::MaskW-1:0] in_use;
		logic [dss_pkg::MaskW-1:0] scope;
		logic [dss_pkg::MaskW-1:0] fresh;
		logic [dss_pkg::MaskW-1:0] dep;
		logic [dss_pkg::MaskW-1:0] sel;
		logic [dss_pkg::MaskW-1:0] fd;
		logic [dss_pkg::MaskW-1:0] od;
		logic [dss_pkg::MaskW-1:0] pf;
		logic [dss_pkg::MaskW-1:0] pd;
		logic [dss_pkg::MaskW-1:0] pre_run;
		logic [dss_pkg::MaskW-1:0] pre_comp;
		logic [dss_pkg::MaskW-1:0] pre_disp;
		logic [dss_pkg::MaskW-1:0] post_disp;
		int unsigned               moved;
		int                        s;
		mask_view_t                view;
		in_use = in_use_bits();
		moved = 0;
		case (kind)
			dss_pkg::KIND_LOAD_DEPS: dep_rows[row] = mask;
			dss_pkg::KIND_REQUEST: req_m |= dependency_closure(mask, in_use);
			dss_pkg::KIND_RESET_STEPS: begin
				runnable_m &= ~mask;
				running_m  &= ~mask;
				req_m      &= ~mask;
				complete_m &= ~mask;
				passed_m   &= ~mask;
			end
			dss_pkg::KIND_RESET_ALL: begin
				req_m      = '0;
				runnable_m = '0;
				running_m  = '0;
				complete_m = '0;
				passed_m   = '0;
			end
			dss_pkg::KIND_POLL: begin
				pre_run  = running_m;
				pre_comp = complete_m;
				pre_disp = runnable_m & ~pre_comp & ~pre_run;
				fresh = '0;
				for (s = 0; s < 32; s++) begin
					dep = dep_rows[s] & in_use;
					if (in_use[s] && !runnable_m[s] && req_m[s] && ((passed_m & dep) == dep))
						fresh[s] = 1'b1;
				end
				runnable_m |= fresh;
				// Dispatch outcomes only touch steps that were dispatchable before the tick.
				sel = pre_disp & in_use;
				fd  = sel & d_fail;
				od  = sel & d_ok & ~d_fail;
				running_m  = (running_m & ~fd) | od;
				complete_m = (complete_m & ~od) | fd;
				passed_m  &= ~(fd | od);
				sel = running_m & in_use;
				pf  = sel & p_fail;
				pd  = sel & p_done & ~p_fail;
				running_m  &= ~(pf | pd);
				complete_m |= pf | pd;
				passed_m    = (passed_m & ~pf) | pd;
				post_disp = runnable_m & ~complete_m & ~running_m;
				moved = $countones(pre_run ^ running_m) + $countones(pre_comp ^ complete_m)
					+ $countones(pre_disp ^ post_disp);
			end
			dss_pkg::KIND_RESET_FAILED: begin
				scope = (scope_runnable ? runnable_m : complete_m) & ~passed_m;
				running_m  &= ~scope;
				complete_m &= ~scope;
			end
			default: ;
		endcase
		scope = scope_runnable ? runnable_m : complete_m;
		view.requested   = req_m;
		view.runnable    = runnable_m;
		view.running     = running_m;
		view.complete    = complete_m;
		view.passed      = passed_m;
		view.failed      = scope & ~passed_m;
		view.transitions = moved[dss_pkg::CountW-1:0];
		expected_views.push_back(view);
	endtask

	always @(posedge clk or negedge arst_n) begin
		mask_view_t want;
		mask_view_t got;
		int         r;
		if (!arst_n) begin
			for (r = 0; r < 32; r++)
				dep_rows[r] = '0;
			req_m      = '0;
			runnable_m = '0;
			running_m  = '0;
			complete_m = '0;
			passed_m   = '0;
			step_count = dss_pkg::StepsReset;
			expected_views.delete();
			mismatches  = 0;
			outstanding = 0;
			checked     = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				step_count = cfg.data;
			if (item.valid && item.ready)
				apply_item(item.kind, item.step_index, item.step_bits, item.include_running,
					item.dispatch_ok_mask, item.dispatch_fail_mask, item.poll_done_mask,
					item.poll_fail_mask);
			if (result.valid && result.ready) begin
				got = {result.requested_now, result.runnable_now, result.running_now,
					result.complete_now, result.passed_now, result.failed_view,
					result.transitions};
				if (expected_views.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing outstanding", $time);
				end else begin
					want = expected_views.pop_front();
					checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: beat %0d exp req %h rnb %h run %h cmp %h pas %h fv %h tr %0d",
								$time, checked, want.requested, want.runnable, want.running,
								want.complete, want.passed, want.failed, want.transitions);
							$display("%0t: beat %0d got req %h rnb %h run %h cmp %h pas %h fv %h tr %0d",
								$time, checked, got.requested, got.runnable, got.running,
								got.complete, got.passed, got.failed, got.transitions);
						end
					end
				end
			end
			outstanding = expected_views.size();
		end
	end

endmodule

/* verif/tb_top.sv */
// Testbench top: clock, reset, item stimulus, output stalls and the final verdict.
`timescale 1ns / 100ps
module tb_top;

	// The kind field is three bits wide; these two codes are defined as no-ops.
	localparam logic [dss_pkg::KindW-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [dss_pkg::KindW-1:0] KIND_SPARE_HI = 3'd7;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned RandomItems = 850;
	localparam int          PhaseCount  = 9;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned cycles = 0;
	int unsigned useful_items = 0;
	int unsigned settings_used = 0;
	int unsigned kind_seen [0:7];
	bit          calm = 1'b0;
	bit          hold_wanted = 1'b0;
	bit          holding = 1'b0;

	dss_cfg_if cfg_ch ();
	dss_in_if  item_ch ();
	dss_out_if result_ch ();

	dependency_step_scoreboard dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	dss_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// One long hold-off on the result side, so the block fills and stalls its input.
	initial begin
		wait (hold_wanted);
		@(posedge clk);
		holding = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		holding = 1'b0;
	end

	initial begin : result_drain
		int unsigned stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 13);
			repeat (stall) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			do begin
				@(negedge clk);
				result_ch.ready <= !holding;
				@(posedge clk);
			end while (!(result_ch.valid && result_ch.ready));
		end
	end

	function automatic logic [dss_pkg::MaskW-1:0] sparse_word(input int unsigned depth);
		logic [dss_pkg::MaskW-1:0] w;
		w = $urandom;
		repeat (depth) w &= $urandom;
		return w;
	endfunction

	function automatic logic [dss_pkg::IdxW-1:0] any_row();
		return dss_pkg::IdxW'($urandom);
	endfunction

	function automatic logic any_flag();
		return 1'($urandom);
	endfunction

	task automatic send_item(input logic [dss_pkg::KindW-1:0] kind,
			input logic [dss_pkg::IdxW-1:0] row,
			input logic [dss_pkg::MaskW-1:0] mask, input logic scope_runnable,
			input logic [dss_pkg::MaskW-1:0] d_ok, input logic [dss_pkg::MaskW-1:0] d_fail,
			input logic [dss_pkg::MaskW-1:0] p_done, input logic [dss_pkg::MaskW-1:0] p_fail);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid              <= 1'b1;
		item_ch.kind               <= kind;
		item_ch.step_index         <= row;
		item_ch.step_bits          <= mask;
		item_ch.include_running    <= scope_runnable;
		item_ch.dispatch_ok_mask   <= d_ok;
		item_ch.dispatch_fail_mask <= d_fail;
		item_ch.poll_done_mask     <= p_done;
		item_ch.poll_fail_mask     <= p_fail;
		do @(posedge clk); while (!item_ch.ready);
		kind_seen[kind]++;
		if (kind <= dss_pkg::KIND_RESET_FAILED)
			useful_items++;
	endtask

	// Poll tick with dense dispatch successes and sparse terminal failures.
	task automatic send_poll();
		send_item(dss_pkg::KIND_POLL, any_row(), $urandom, any_flag(), $urandom | $urandom,
			sparse_word($urandom_range(2, 4)), $urandom, sparse_word($urandom_range(2, 4)));
	endtask

	task automatic send_noise();
		send_item(dss_pkg::KindW'($urandom_range(0, 7)), any_row(), $urandom, any_flag(),
			$urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic set_step_count(input logic [dss_pkg::StepsW-1:0] count);
		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= count;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// A typical flow: clear, build a mostly acyclic table, request, then drive it with ticks.
	task automatic run_flow();
		logic [dss_pkg::MaskW-1:0] lower;
		logic [dss_pkg::IdxW-1:0]  row;
		int unsigned               ticks;
		int unsigned               pick;
		send_item(dss_pkg::KIND_RESET_ALL, any_row(), $urandom, any_flag(), $urandom, $urandom,
			$urandom, $urandom);
		repeat ($urandom_range(2, 12)) begin
			row = any_row();
			lower = (row == 0) ? '0 : (32'hFFFF_FFFF >> (32 - row));
			send_item(dss_pkg::KIND_LOAD_DEPS, row,
				($urandom_range(0, 7) == 0) ? sparse_word(3)
					: (sparse_word($urandom_range(1, 3)) & lower),
				any_flag(), $urandom, $urandom, $urandom, $urandom);
		end
		send_item(dss_pkg::KIND_REQUEST, any_row(),
			($urandom_range(0, 3) == 0) ? $urandom : sparse_word(2),
			any_flag(), $urandom, $urandom, $urandom, $urandom);
		ticks = $urandom_range(6, 16);
		repeat (ticks) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				send_item(dss_pkg::KIND_RESET_FAILED, any_row(), $urandom, any_flag(),
					$urandom, $urandom, $urandom, $urandom);
			else if (pick == 2)
				send_item(dss_pkg::KIND_RESET_STEPS, any_row(), sparse_word(2), any_flag(),
					$urandom, $urandom, $urandom, $urandom);
			else if (pick == 3)
				send_item(dss_pkg::KIND_REQUEST, any_row(), sparse_word(3), any_flag(),
					$urandom, $urandom, $urandom, $urandom);
			else
				send_poll();
		end
	endtask

	initial begin
		logic [dss_pkg::StepsW-1:0] step_counts [0:PhaseCount-1];
		int unsigned                target;
		int                         p;
		step_counts = '{6'd32, 6'd5, 6'd0, 6'd63, 6'd1, 6'd17, 6'd40, 6'd31, 6'd32};
		foreach (kind_seen[k])
			kind_seen[k] = 0;
		arst_n = 1'b0;
		item_ch.valid              = 1'b0;
		item_ch.kind               = dss_pkg::KIND_LOAD_DEPS;
		item_ch.step_index         = '0;
		item_ch.step_bits          = '0;
		item_ch.include_running    = 1'b0;
		item_ch.dispatch_ok_mask   = '0;
		item_ch.dispatch_fail_mask = '0;
		item_ch.poll_done_mask     = '0;
		item_ch.poll_fail_mask     = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: chain 0 <- 1 <- 2, a cycle between 3 and 4, step 31 needing everything.
		send_item(dss_pkg::KIND_POLL, 5'd0, '1, 1'b1, '1, '1, '1, '1);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd0, 32'h0, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd1, 32'h1, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd2, 32'h2, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd3, 32'h10, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd4, 32'h8, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_LOAD_DEPS, 5'd31, '1, 1'b1, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_REQUEST, 5'd0, 32'h4, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_REQUEST, 5'd0, 32'h8, 1'b1, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b1, '1, '0, '0, '0);
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b0, '1, '0, '1, '0);
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b1, '1, '0, '0, '0);
		// A dispatch failure wins over a success on the same step.
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b0, '1, 32'h2, '0, '0);
		send_item(dss_pkg::KIND_RESET_FAILED, 5'd0, '0, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b1, '1, '0, '0, '0);
		// A poll failure wins over completion on the same step.
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b0, '0, '0, '1, 32'h2);
		send_item(dss_pkg::KIND_RESET_FAILED, 5'd0, '0, 1'b1, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_REQUEST, 5'd0, '1, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_POLL, 5'd31, '1, 1'b1, '1, '0, '1, '0);
		send_item(KIND_SPARE_LO, 5'd31, '1, 1'b1, '1, '1, '1, '1);
		send_item(KIND_SPARE_HI, 5'd0, '0, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_RESET_STEPS, 5'd0, 32'h5, 1'b1, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_REQUEST, 5'd0, '0, 1'b0, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_RESET_ALL, 5'd0, '0, 1'b1, '0, '0, '0, '0);
		send_item(dss_pkg::KIND_POLL, 5'd0, '0, 1'b0, '0, '0, '0, '0);

		target = useful_items;
		for (p = 0; p < PhaseCount; p++) begin
			set_step_count(step_counts[p]);
			target += RandomItems / PhaseCount;
			while (useful_items < target) begin
				calm = ($urandom_range(0, 4) == 0);
				if (!hold_wanted && useful_items > 400)
					hold_wanted = 1'b1;
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 6)) send_noise();
				else
					run_flow();
			end
		end
		calm = 1'b0;

		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		$display("Covered %0d items: %0d requests, %0d poll ticks, %0d failure resets, %0d no-ops.",
			useful_items, kind_seen[dss_pkg::KIND_REQUEST], kind_seen[dss_pkg::KIND_POLL],
			kind_seen[dss_pkg::KIND_RESET_FAILED],
			kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_HI]);
		$display("Used %0d step-count settings and checked %0d result beats.",
			settings_used, checked);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
rtl/core/dss_pkg.sv
rtl/core/dss_if.sv
rtl/core/dss_lane.sv
rtl/core/dss_merge.sv
rtl/core/dependency_step_scoreboard.sv
rtl/core/dss_checker.sv
verif/dss_checker.sv
verif/tb_top.sv
